### rtl/core/bilinear_fit_gradient_accumulator_assert.svh
// Assertion macros for the bilinear fit gradient accumulator
`ifndef BILINEAR_FIT_GRADIENT_ACCUMULATOR_ASSERT_SVH
`define BILINEAR_FIT_GRADIENT_ACCUMULATOR_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BFG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define BFG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

### rtl/core/bfga_pkg.sv
package bfga_pkg;
	localparam int PIX_W  = 8;
	localparam int CORN_W = 16;
	localparam int DIM_W  = 13;
	localparam int INV_W  = 17;
	localparam int OUT_W  = 26;
	localparam int SUM_W  = 52;

	// register indexes
	localparam logic [2:0] REG_TL = 3'd0;
	localparam logic [2:0] REG_TR = 3'd1;
	localparam logic [2:0] REG_BL = 3'd2;
	localparam logic [2:0] REG_BR = 3'd3;
	localparam logic [2:0] REG_W  = 3'd4;
	localparam logic [2:0] REG_H  = 3'd5;
	localparam logic [2:0] REG_IW = 3'd6;
	localparam logic [2:0] REG_IH = 3'd7;

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WGT   = 5'b00010,
		ST_ACC   = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;     // capture pixel, form weights
		logic model;    // form corner products
		logic err;      // form model value and error
		logic acc;      // accumulate terms, advance counters
		logic fin_start; // start end-of-frame scaling
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic frame_end;
		logic fin_done;
	} sts_t;
endpackage

### rtl/core/bilinear_fit_gradient_accumulator.sv
// Each pixel passes through four steps (weights, corner products, model error, accumulate).
// The sequential controller holds in_stall high until a pixel is accumulated, so pixels do not overlap.
// At end of frame the shared scaling multiplier runs before the result word:
// 3 steps for each of the four corners, then one to flag completion.
// Reset (arst_n low) loads corner registers to 65280, sizes to 1,
// reciprocals to 65536, and clears counters and sums.
module bilinear_fit_gradient_accumulator #(
	parameter int DIM_BITS  = 12,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [bfga_pkg::PIX_W-1:0] pixel,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [bfga_pkg::OUT_W-1:0] grad_top_left,
	output logic signed [bfga_pkg::OUT_W-1:0] grad_top_right,
	output logic signed [bfga_pkg::OUT_W-1:0] grad_bottom_left,
	output logic signed [bfga_pkg::OUT_W-1:0] grad_bottom_right,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import bfga_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [CORN_W-1:0] tl_q, tr_q, bl_q, br_q;
	logic [DIM_W-1:0]  w_q, h_q;
	logic [INV_W-1:0]  iw_q, ih_q;

	assign cfg_ready = 1'b1;

	// write configuration word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q <= 16'd65280;
			tr_q <= 16'd65280;
			bl_q <= 16'd65280;
			br_q <= 16'd65280;
			w_q  <= 13'd1;
			h_q  <= 13'd1;
			iw_q <= 17'd65536;
			ih_q <= 17'd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TL: tl_q <= cfg_data[CORN_W-1:0];
				REG_TR: tr_q <= cfg_data[CORN_W-1:0];
				REG_BL: bl_q <= cfg_data[CORN_W-1:0];
				REG_BR: br_q <= cfg_data[CORN_W-1:0];
				REG_W:  w_q  <= cfg_data[DIM_W-1:0];
				REG_H:  h_q  <= cfg_data[DIM_W-1:0];
				REG_IW: iw_q <= cfg_data[INV_W-1:0];
				REG_IH: ih_q <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	bfga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	bfga_dp #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pixel     (pixel),
		.corn_tl   (tl_q),
		.corn_tr   (tr_q),
		.corn_bl   (bl_q),
		.corn_br   (br_q),
		.width_cfg (w_q),
		.height_cfg(h_q),
		.inv_w     (iw_q),
		.inv_h     (ih_q),
		.grad_tl   (grad_top_left),
		.grad_tr   (grad_top_right),
		.grad_bl   (grad_bottom_left),
		.grad_br   (grad_bottom_right)
	);
endmodule

### rtl/core/bfga_ctrl.sv
module bfga_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output bfga_pkg::cmd_t cmd,
	input  bfga_pkg::sts_t sts
);
	import bfga_pkg::*;
	`include "bilinear_fit_gradient_accumulator_assert.svh"

	state_t state_q;
	// step flag within ST_WGT: low for corner products, high for model error
	logic   mdl_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.model     = (state_q == ST_WGT) && !mdl_q;
		cmd.err       = (state_q == ST_WGT) && mdl_q;
		cmd.acc       = (state_q == ST_ACC);
		cmd.fin_start = (state_q == ST_ACC) && sts.frame_end;
	end

	// advance the sequence for one pixel and the end-of-frame output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mdl_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_WGT;
					mdl_q <= 1'b0;
				end
				ST_WGT: begin
					if (mdl_q) state_q <= ST_ACC;
					mdl_q <= 1'b1;
				end
				ST_ACC: begin
					state_q <= sts.frame_end ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if (sts.fin_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BFG_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_q))
	`BFG_ASSERT_NEXT(a_load_wgt, cmd.load, state_q == ST_WGT)
	`BFG_ASSERT_IMP(a_no_acc_out, out_valid, !cmd.acc)
endmodule

### rtl/core/bfga_dp.sv
module bfga_dp #(
	parameter int DIM_BITS  = 12,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfga_pkg::cmd_t                cmd,
	output bfga_pkg::sts_t                sts,
	input  logic [bfga_pkg::PIX_W-1:0]    pixel,
	input  logic [bfga_pkg::CORN_W-1:0]   corn_tl,
	input  logic [bfga_pkg::CORN_W-1:0]   corn_tr,
	input  logic [bfga_pkg::CORN_W-1:0]   corn_bl,
	input  logic [bfga_pkg::CORN_W-1:0]   corn_br,
	input  logic [bfga_pkg::DIM_W-1:0]    width_cfg,
	input  logic [bfga_pkg::DIM_W-1:0]    height_cfg,
	input  logic [bfga_pkg::INV_W-1:0]    inv_w,
	input  logic [bfga_pkg::INV_W-1:0]    inv_h,
	output logic signed [bfga_pkg::OUT_W-1:0] grad_tl,
	output logic signed [bfga_pkg::OUT_W-1:0] grad_tr,
	output logic signed [bfga_pkg::OUT_W-1:0] grad_bl,
	output logic signed [bfga_pkg::OUT_W-1:0] grad_br
);
	import bfga_pkg::*;

	localparam int FW   = FRAC_BITS + 1;           // width of Q1.F value up to ONE
	localparam int CW   = DIM_BITS + 1;            // dimension width incl. 1<<DIM_BITS
	localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] DMAX = CW'(1) << DIM_BITS;
	localparam int MW   = CORN_W + FW;             // corner times weight
	localparam int EW   = CORN_W + 3;              // 2*(m - p<<8), signed
	localparam int TW   = EW + FW;                 // product e2*w
	localparam int SW   = SUM_W;
	localparam int MAGW = SUM_W;
	localparam int CAPW = OUT_W + FRAC_BITS + 1;
	localparam logic [CAPW-1:0] CAP = CAPW'(1) << (OUT_W + FRAC_BITS);
	localparam int FACW = (MAGW > CAPW) ? MAGW : CAPW;

	// counters and positions
	logic [DIM_BITS-1:0] col_q, row_q;
	logic [FW-1:0]       xf_q, yf_q;
	logic [PIX_W-1:0]    pix_q;
	logic [FW-1:0]       w_q [4];
	logic [MW-1:0]       cw_q [4];
	logic signed [SW-1:0] sum_q [4];

	logic [FW-1:0] x, y, omx, omy;
	logic [CW-1:0] wd, hd;
	logic          row_end, frm_end;

	assign x   = (xf_q > ONE) ? ONE : xf_q;
	assign y   = (yf_q > ONE) ? ONE : yf_q;
	assign omx = ONE - x;
	assign omy = ONE - y;

	assign wd = (width_cfg == '0) ? CW'(1) :
		((CW'(width_cfg) > DMAX) ? DMAX : CW'(width_cfg));
	assign hd = (height_cfg == '0) ? CW'(1) :
		((CW'(height_cfg) > DMAX) ? DMAX : CW'(height_cfg));
	assign row_end = !((CW'(col_q) + CW'(1)) < wd);
	assign frm_end = row_end && !((CW'(row_q) + CW'(1)) < hd);

	// stage 1: weights
	logic [2*FW-1:0] p0, p1, p2, p3;
	assign p0 = omy * omx;
	assign p1 = omy * x;
	assign p2 = y * omx;
	assign p3 = y * x;

	// stage 3: model value and error
	logic [MW+1:0]        msum;
	logic [CORN_W-1:0]    m;
	logic signed [EW-1:0] e2;
	logic signed [EW-1:0] e2_q;

	assign msum = (MW+2)'(cw_q[0]) + (MW+2)'(cw_q[1]) + (MW+2)'(cw_q[2]) + (MW+2)'(cw_q[3]);
	assign m    = CORN_W'(msum >> FRAC_BITS);
	assign e2   = (EW'($signed({1'b0, m})) - EW'($signed({1'b0, pix_q, 8'd0}))) <<< 1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q  <= pixel;
			w_q[0] <= FW'(p0 >> FRAC_BITS);
			w_q[1] <= FW'(p1 >> FRAC_BITS);
			w_q[2] <= FW'(p2 >> FRAC_BITS);
			w_q[3] <= FW'(p3 >> FRAC_BITS);
		end
		// stage 2: corner products
		if (cmd.model) begin
			cw_q[0] <= MW'(corn_tl) * MW'(w_q[0]);
			cw_q[1] <= MW'(corn_tr) * MW'(w_q[1]);
			cw_q[2] <= MW'(corn_bl) * MW'(w_q[2]);
			cw_q[3] <= MW'(corn_br) * MW'(w_q[3]);
		end
		// hold the error for the accumulate step
		if (cmd.err) e2_q <= e2;
	end

	// stage 4: terms and saturating sums
	logic signed [TW-1:0] prod [4];
	logic signed [TW-1:0] term [4];
	logic signed [SW:0]   nsum [4];
	logic signed [SW-1:0] sat  [4];
	localparam logic signed [SW:0] SMAX = (SW+1)'({1'b0, {(SW-1){1'b1}}});
	localparam logic signed [SW:0] SMIN = -SMAX - (SW+1)'(1);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i] = e2_q * $signed({1'b0, w_q[i]});
			term[i] = prod[i] >>> 8;
			nsum[i] = (SW+1)'(sum_q[i]) + (SW+1)'(term[i]);
			if (nsum[i] > SMAX)      sat[i] = SW'(SMAX);
			else if (nsum[i] < SMIN) sat[i] = SW'(SMIN);
			else                     sat[i] = SW'(nsum[i]);
		end
	end

	// finishing unit: shared, one scale step per cycle, one corner at a time
	logic [1:0]        fidx_q;
	logic [1:0]        fph_q;     // 0 load magnitude, 1 x-scale, 2 y-scale
	logic              fbusy_q;
	logic              fneg_q;
	logic [FACW-1:0]   fmag_q;
	logic              fdone_q;
	logic signed [SW-1:0] snap_q [4];
	logic signed [OUT_W-1:0] g_q [4];

	logic [INV_W-1:0]  finv;
	logic [FACW-1:0]   fhi, flo;
	logic [FACW+INV_W-1:0] fprod_hi;
	logic [FRAC_BITS+INV_W-1:0] fprod_lo;
	logic [FACW+INV_W:0] fres;
	logic signed [SW-1:0] cur;
	logic [SW-1:0] cmag;
	localparam logic [OUT_W:0] LIM = (OUT_W+1)'(1) << (OUT_W-1);

	assign cur  = snap_q[fidx_q];
	assign cmag = cur[SW-1] ? SW'(-cur) : SW'(cur);
	assign finv = (fph_q == 2'd1) ? inv_w : inv_h;
	assign fhi  = fmag_q >> FRAC_BITS;
	assign flo  = fmag_q & FACW'((FACW'(1) << FRAC_BITS) - 1);
	assign fprod_hi = fhi * finv;
	assign fprod_lo = (FRAC_BITS+INV_W)'(flo) * finv;
	assign fres = (FACW+INV_W+1)'(fprod_hi) + (FACW+INV_W+1)'(fprod_lo >> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			xf_q    <= '0;
			yf_q    <= '0;
			fbusy_q <= 1'b0;
			fph_q   <= 2'd0;
			fidx_q  <= 2'd0;
			fdone_q <= 1'b0;
			fneg_q  <= 1'b0;
			fmag_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				sum_q[i]  <= '0;
				snap_q[i] <= '0;
				g_q[i]    <= '0;
			end
		end else begin
			fdone_q <= 1'b0;
			if (cmd.acc) begin
				if (frm_end) begin
					for (int i = 0; i < 4; i++) begin
						snap_q[i] <= sat[i];
						sum_q[i]  <= '0;
					end
				end else begin
					for (int i = 0; i < 4; i++) sum_q[i] <= sat[i];
				end
				// advance position
				if (!row_end) begin
					col_q <= col_q + DIM_BITS'(1);
					xf_q  <= ((FW+1)'(xf_q) + (FW+1)'(inv_w) > (FW+1)'(ONE)) ? ONE
						: FW'(xf_q + FW'(inv_w));
				end else begin
					col_q <= '0;
					xf_q  <= '0;
					if (!frm_end) begin
						row_q <= row_q + DIM_BITS'(1);
						yf_q  <= ((FW+1)'(yf_q) + (FW+1)'(inv_h) > (FW+1)'(ONE)) ? ONE
							: FW'(yf_q + FW'(inv_h));
					end else begin
						row_q <= '0;
						yf_q  <= '0;
					end
				end
			end
			// scaling sequence
			if (cmd.fin_start) begin
				fbusy_q <= 1'b1;
				fph_q   <= 2'd0;
				fidx_q  <= 2'd0;
			end else if (fbusy_q) begin
				case (fph_q)
					2'd0: begin
						fneg_q <= cur[SW-1];
						fmag_q <= FACW'(cmag);
						fph_q  <= 2'd1;
					end
					2'd1: begin
						fmag_q <= (fres > (FACW+INV_W+1)'(CAP)) ? FACW'(CAP) : FACW'(fres);
						fph_q  <= 2'd2;
					end
					default: begin
						if (fneg_q)
							g_q[fidx_q] <= (fres > (FACW+INV_W+1)'(LIM)) ?
								-OUT_W'(LIM) : -OUT_W'(fres);
						else
							g_q[fidx_q] <= (fres > (FACW+INV_W+1)'(LIM - 1)) ?
								OUT_W'(LIM - 1) : OUT_W'(fres);
						fph_q  <= 2'd0;
						fidx_q <= fidx_q + 2'd1;
						if (fidx_q == 2'd3) begin
							fbusy_q <= 1'b0;
							fdone_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	assign sts.frame_end = frm_end;
	assign sts.fin_done  = fdone_q;
	assign grad_tl = g_q[0];
	assign grad_tr = g_q[1];
	assign grad_bl = g_q[2];
	assign grad_br = g_q[3];
endmodule
